FILE: rtl/btaa_pkg.sv
// ----------------------------------------------------------------------------
// btaa_pkg
// Shared types and constants of the binary tree address allocator.
// ----------------------------------------------------------------------------
package btaa_pkg;

  localparam int MaxHostBitsDef = 8;
  localparam int CfgW           = 4;
  localparam int AddrFieldW     = 8;
  localparam int CountW         = 9;
  localparam int StatusW        = 3;

  localparam logic [CfgW-1:0] HostBitsRst = 4'd8;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STAT_GOT_REQ     = 3'd0,
    STAT_GOT_OTHER   = 3'd1,
    STAT_OCCUPIED    = 3'd2,
    STAT_POOL_FULL   = 3'd3,
    STAT_FREED       = 3'd4,
    STAT_NOT_FOUND   = 3'd5,
    STAT_DOUBLE_FREE = 3'd6
  } status_e;

  // One memory word per internal node: exists and full bits of both children
  typedef struct packed {
    logic ex_r;
    logic full_r;
    logic ex_l;
    logic full_l;
  } entry_t;

  typedef struct packed {
    status_e               status;
    logic [AddrFieldW-1:0] granted_address;
    logic                  pool_full;
    logic [CountW-1:0]     allocated_count;
  } result_t;

  function automatic logic node_full(entry_t e);
    node_full = e.ex_l & e.full_l & e.ex_r & e.full_r;
  endfunction

endpackage

FILE: rtl/btaa_node_ram.sv
// ----------------------------------------------------------------------------
// btaa_node_ram
// Node memory: one word per internal node, one write and one registered read.
// ----------------------------------------------------------------------------
module btaa_node_ram #(
  parameter int AW = btaa_pkg::MaxHostBitsDef
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output btaa_pkg::entry_t  rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  btaa_pkg::entry_t  wr_data_i
);

  btaa_pkg::entry_t mem [2**AW];
  btaa_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/btaa_seq.sv
// ----------------------------------------------------------------------------
// btaa_seq
// Sequencer: clearing sweep, walk down the tree, full-bit update walk back up.
// ----------------------------------------------------------------------------
module btaa_seq #(
  parameter int MAX_HOST_BITS = btaa_pkg::MaxHostBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [btaa_pkg::CfgW-1:0]           host_bits_i,
  input  logic                                cfg_we_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_cmd_i,
  input  logic [btaa_pkg::AddrFieldW-1:0]     in_addr_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output btaa_pkg::result_t                   res_o,
  output logic                                rd_en_o,
  output logic [MAX_HOST_BITS-1:0]            rd_addr_o,
  input  btaa_pkg::entry_t                    rd_data_i,
  output logic                                wr_en_o,
  output logic [MAX_HOST_BITS-1:0]            wr_addr_o,
  output btaa_pkg::entry_t                    wr_data_o
);

  localparam int AW = MAX_HOST_BITS;
  localparam int LW = $clog2(MAX_HOST_BITS + 1);
  localparam int FW = btaa_pkg::AddrFieldW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DOWN  = 3'd2;
  localparam logic [2:0] ST_UP    = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [AW-1:0]                clr_q, clr_d;
  logic [AW-1:0]                node_q, node_d;
  logic [LW-1:0]                lvl_q, lvl_d;
  logic [AW-1:0]                addr_q, addr_d;
  logic                         cmd_q, cmd_d;
  logic                         any_q, any_d;
  btaa_pkg::status_e            status_q, status_d;
  logic                         sub_full_q, sub_full_d;
  logic                         side_q, side_d;
  logic                         root_full_q, root_full_d;
  logic [btaa_pkg::CountW-1:0]  used_q, used_d;

  logic [LW-1:0]  hb;
  logic [AW:0]    mask_w;
  logic [AW+FW-1:0] addr_wide;
  logic [AW-1:0]  in_masked;
  logic [AW-1:0]  addr_sh;
  logic [AW-1:0]  bit_at;
  logic [AW-1:0]  node_shl;
  logic [AW-1:0]  child;
  logic [AW-1:0]  parent;
  logic           b;
  logic           ch_ex;
  logic           ch_full;
  logic           leaf;
  btaa_pkg::entry_t down_e;
  btaa_pkg::entry_t up_e;
  logic [AW+FW-1:0] grant_wide;

  always_comb begin
    if (host_bits_i == '0) begin
      hb = LW'(1);
    end else if (32'(host_bits_i) > MAX_HOST_BITS) begin
      hb = LW'(MAX_HOST_BITS);
    end else begin
      hb = LW'(host_bits_i);
    end
  end

  assign mask_w    = ((AW + 1)'(1) << hb) - (AW + 1)'(1);
  assign addr_wide = {{AW{1'b0}}, in_addr_i};
  assign in_masked = addr_wide[AW-1:0] & mask_w[AW-1:0];

  assign addr_sh  = addr_q >> (lvl_q - LW'(1));
  assign bit_at   = AW'(1) << (lvl_q - LW'(1));
  assign node_shl = node_q << 1;
  assign parent   = node_q >> 1;
  assign leaf     = (lvl_q == LW'(1));

  assign b       = any_q ? rd_data_i.full_l : addr_sh[0];
  assign ch_ex   = b ? rd_data_i.ex_r : rd_data_i.ex_l;
  assign ch_full = b ? rd_data_i.full_r : rd_data_i.full_l;
  assign child   = node_shl | AW'(b);

  always_comb begin
    down_e = rd_data_i;
    if (cmd_q == btaa_pkg::CmdAlloc) begin
      if (b || any_q) begin
        down_e.ex_l = down_e.ex_l | ~b | any_q;
      end
      if (b) begin
        down_e.ex_r = 1'b1;
      end else begin
        down_e.ex_l = 1'b1;
      end
      if (leaf && !ch_full) begin
        if (b) begin
          down_e.full_r = 1'b1;
        end else begin
          down_e.full_l = 1'b1;
        end
      end
    end else if (leaf) begin
      if (b) begin
        down_e.full_r = 1'b0;
      end else begin
        down_e.full_l = 1'b0;
      end
    end
  end

  always_comb begin
    up_e = rd_data_i;
    if (side_q) begin
      up_e.full_r = sub_full_q;
    end else begin
      up_e.full_l = sub_full_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    lvl_d       = lvl_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    any_d       = any_q;
    status_d    = status_q;
    sub_full_d  = sub_full_q;
    side_d      = side_q;
    root_full_d = root_full_q;
    used_d      = used_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = node_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = node_q;
    wr_data_o   = down_e;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_q;
        wr_data_o = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d  = in_cmd_i;
          addr_d = in_masked;
          any_d  = (in_cmd_i == btaa_pkg::CmdAlloc) && (in_masked == '0);
          lvl_d  = hb;
          node_d = AW'(1);
          if ((in_cmd_i == btaa_pkg::CmdAlloc) && (in_masked == '0) && root_full_q) begin
            status_d = btaa_pkg::STAT_POOL_FULL;
            state_d  = ST_DONE;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = AW'(1);
            state_d   = ST_DOWN;
          end
        end
      end
      ST_DOWN: begin
        if (cmd_q == btaa_pkg::CmdFree) begin
          if (!ch_ex) begin
            status_d = btaa_pkg::STAT_NOT_FOUND;
            state_d  = ST_DONE;
          end else if (leaf) begin
            if (ch_full) begin
              wr_en_o  = 1'b1;
              status_d = btaa_pkg::STAT_FREED;
              if (used_q != '0) begin
                used_d = used_q - btaa_pkg::CountW'(1);
              end
            end else begin
              status_d = btaa_pkg::STAT_DOUBLE_FREE;
              state_d  = ST_DONE;
            end
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = child;
            node_d    = child;
            lvl_d     = lvl_q - LW'(1);
          end
        end else begin
          wr_en_o = 1'b1;
          if (b) begin
            addr_d = addr_q | bit_at;
          end
          if (leaf) begin
            if (ch_full) begin
              status_d = btaa_pkg::STAT_OCCUPIED;
              state_d  = ST_DONE;
            end else begin
              status_d = any_q ? btaa_pkg::STAT_GOT_OTHER : btaa_pkg::STAT_GOT_REQ;
              if (used_q != '1) begin
                used_d = used_q + btaa_pkg::CountW'(1);
              end
            end
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = child;
            node_d    = child;
            lvl_d     = lvl_q - LW'(1);
          end
        end
        // Leaf changed: start the walk back up
        if (leaf && (ch_full == (cmd_q == btaa_pkg::CmdFree))) begin
          sub_full_d = btaa_pkg::node_full(down_e);
          if (node_q == AW'(1)) begin
            root_full_d = btaa_pkg::node_full(down_e);
            state_d     = ST_DONE;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = parent;
            side_d    = node_q[0];
            node_d    = parent;
            state_d   = ST_UP;
          end
        end
      end
      ST_UP: begin
        wr_en_o    = 1'b1;
        wr_data_o  = up_e;
        sub_full_d = btaa_pkg::node_full(up_e);
        if (node_q == AW'(1)) begin
          root_full_d = btaa_pkg::node_full(up_e);
          state_d     = ST_DONE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = parent;
          side_d    = node_q[0];
          node_d    = parent;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      state_d     = ST_CLEAR;
      clr_d       = '0;
      used_d      = '0;
      root_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      used_q      <= '0;
      root_full_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      used_q      <= used_d;
      root_full_q <= root_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    lvl_q      <= lvl_d;
    addr_q     <= addr_d;
    cmd_q      <= cmd_d;
    any_q      <= any_d;
    status_q   <= status_d;
    sub_full_q <= sub_full_d;
    side_q     <= side_d;
  end

  assign grant_wide = {{FW{1'b0}}, addr_q};

  always_comb begin
    res_o.status          = status_q;
    res_o.granted_address = '0;
    if ((status_q == btaa_pkg::STAT_GOT_REQ) || (status_q == btaa_pkg::STAT_GOT_OTHER)) begin
      res_o.granted_address = grant_wide[FW-1:0];
    end
    res_o.pool_full       = root_full_q;
    res_o.allocated_count = used_q;
  end

endmodule

FILE: rtl/binary_tree_address_allocator.sv
// ----------------------------------------------------------------------------
// binary_tree_address_allocator
// Host address allocator over a binary tree of subtree-full bits.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser is the command (allocate or
// free), tdata the address; an allocate of address 0 takes the lowest free
// address. Each request gives one transfer on m_axis: tuser the status,
// tdata the granted address, the pool-full flag and the allocated count.
// The host_bits register (cfg_we_i, cfg_wdata_i) sets the pool size and
// empties the pool.
// A request walks from the root down to its leaf and, when the leaf
// changes, back up to the root; the walk stops early when no leaf changes.
// The next request is taken only once the result has been handed on.
// The node memory is read once per tree level on the way down and on the
// way up, one item at a time. The output register holds a result while the
// receiver stalls; the next request is taken meanwhile and waits in the
// sequencer.
// After reset and after every host_bits write a clearing pass that writes
// all 2^MAX_HOST_BITS node words (256 by default) empties the node memory;
// s_axis_tready stays low during it.
// ----------------------------------------------------------------------------
module binary_tree_address_allocator #(
  parameter int MAX_HOST_BITS = btaa_pkg::MaxHostBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [btaa_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] address
  input  logic [0:0]                s_axis_tuser,   // [0] cmd
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // [7:0] granted_address,
                                                    // [8] pool_full,
                                                    // [17:9] allocated_count
  output logic [2:0]                m_axis_tuser    // [2:0] status
);

  localparam int AW = MAX_HOST_BITS;

  logic [btaa_pkg::CfgW-1:0] host_bits_q;
  logic                      out_valid_q;
  btaa_pkg::result_t         out_q;
  btaa_pkg::result_t         res;
  logic                      res_valid;
  logic                      res_ready;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  btaa_pkg::entry_t          rd_data;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  btaa_pkg::entry_t          wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_bits_q <= btaa_pkg::HostBitsRst;
    end else if (cfg_we_i) begin
      host_bits_q <= cfg_wdata_i;
    end
  end

  btaa_seq #(
    .MAX_HOST_BITS(MAX_HOST_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .host_bits_i (host_bits_q),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser[0]),
    .in_addr_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  btaa_node_ram #(
    .AW(AW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {6'd0, out_q.allocated_count, out_q.pool_full,
                          out_q.granted_address};

endmodule

FILE: rtl/btaa_checker.sv
// ----------------------------------------------------------------------------
// btaa_checker
// Port-level checks of the address allocator, bound to the top level.
// ----------------------------------------------------------------------------
module btaa_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [23:0]               m_axis_tdata,
  input logic [2:0]                m_axis_tuser
);

  logic granted;

  assign granted = (m_axis_tuser == btaa_pkg::STAT_GOT_REQ) ||
                   (m_axis_tuser == btaa_pkg::STAT_GOT_OTHER);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output transfer changed while stalled");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !granted |-> m_axis_tdata[7:0] == 8'd0)
    else $error("granted address nonzero without a grant");

  a_grant_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && granted |-> m_axis_tdata[17:9] != 9'd0)
    else $error("grant reported with zero allocated count");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == btaa_pkg::STAT_POOL_FULL) |-> m_axis_tdata[8])
    else $error("pool full status without pool full flag");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("request accepted during clearing pass");

endmodule

bind binary_tree_address_allocator btaa_checker u_btaa_checker (.*);
